// ===== sv/gbr_pkg.sv =====
// Shared types and constants for the 3x3 RGB blur block.
// Used by gbr_front, gbr_queue, gbr_back and the top level; no dependencies.
package gbr_pkg;

  localparam int unsigned MAX_WIDTH_DEF    = 1024;
  localparam int unsigned FRAME_WIDTH_RST  = 640;
  localparam int unsigned FRAME_HEIGHT_RST = 480;

  localparam int unsigned FW_W       = 11;
  localparam int unsigned FH_W       = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned PX_W       = 3 * CH_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic            shift;
    logic            emit;
    logic            zero;
    logic            last;
    logic [PX_W-1:0] top;
    logic [PX_W-1:0] mid;
    logic [PX_W-1:0] px;
  } cmd_t;

endpackage

// ===== sv/gbr_front.sv =====
// Front end: configuration registers, frame position counters, line buffers.
// Classifies beats; pixels, frame-end drains push a command; uses gbr_pkg.
module gbr_front #(
  parameter int unsigned MAX_WIDTH = gbr_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gbr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gbr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_req_type,
  input  logic [gbr_pkg::PX_W-1:0]           in_px,
  input  logic [gbr_pkg::QCNT_W-1:0]         q_count,
  output logic                               push_valid,
  output gbr_pkg::cmd_t                      push_data
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned FH_W  = gbr_pkg::FH_W;
  localparam int unsigned PX_W  = gbr_pkg::PX_W;
  localparam int unsigned RST_W = (gbr_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                                  MAX_WIDTH : gbr_pkg::FRAME_WIDTH_RST;

  logic [CW-1:0]     w_last_r, w_last_nxt;
  logic [FH_W-1:0]   h_last_r, h_last_nxt;
  logic [CW-1:0]     in_col_r, in_col_nxt;
  logic [FH_W-1:0]   in_row_r, in_row_nxt;
  logic [CW-1:0]     out_col_r, out_col_nxt;
  logic [FH_W-1:0]   out_row_r, out_row_nxt;
  logic              s1_v_r, s1_v_nxt;
  logic              s1_shift_r, s1_shift_nxt;
  logic              s1_emit_r, s1_emit_nxt;
  logic              s1_zero_r, s1_zero_nxt;
  logic              s1_last_r, s1_last_nxt;
  logic [CW-1:0]     s1_col_r;
  logic [PX_W-1:0]   s1_px_r;
  logic [2*PX_W-1:0] rd_data_r;
  logic [2*PX_W-1:0] line_mem [MAX_WIDTH];

  logic                         in_fire, cfg_fire, rd_en;
  logic                         in_origin, out_origin;
  logic [CW-1:0]                out_col_use;
  logic [FH_W-1:0]              out_row_use;
  logic                         emit;
  logic [gbr_pkg::FW_W-1:0]     fw;
  logic [FH_W-1:0]              fh;
  logic [gbr_pkg::QCNT_W:0]     used;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign used      = (gbr_pkg::QCNT_W + 1)'(q_count) + (gbr_pkg::QCNT_W + 1)'(s1_v_r);
  assign in_ready  = !cfg_valid &&
                     (used < (gbr_pkg::QCNT_W + 1)'(gbr_pkg::QUEUE_DEPTH));
  assign in_fire   = in_valid && in_ready;
  assign rd_en     = in_fire && !cfg_fire && (in_req_type == gbr_pkg::REQ_PIXEL);

  assign in_origin  = (in_col_r == '0) && (in_row_r == '0);
  assign out_origin = (out_col_r == '0) && (out_row_r == '0);

  assign fw = cfg_data[gbr_pkg::FW_W-1:0];
  assign fh = cfg_data[FH_W-1:0];

  always_comb begin
    w_last_nxt   = w_last_r;
    h_last_nxt   = h_last_r;
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_col_use  = out_col_r;
    out_row_use  = out_row_r;
    emit         = 1'b0;
    s1_v_nxt     = 1'b0;
    s1_shift_nxt = 1'b0;
    if (cfg_fire) begin
      case (cfg_index)
        gbr_pkg::CFG_FRAME_WIDTH: begin
          if (int'(fw) > MAX_WIDTH) begin
            w_last_nxt = CW'(MAX_WIDTH - 1);
          end else if (fw < gbr_pkg::FW_W'(3)) begin
            w_last_nxt = CW'(2);
          end else begin
            w_last_nxt = CW'(fw - gbr_pkg::FW_W'(1));
          end
        end
        gbr_pkg::CFG_FRAME_HEIGHT: begin
          h_last_nxt = (fh < FH_W'(3)) ? FH_W'(2) : fh - FH_W'(1);
        end
        default: begin
          w_last_nxt = w_last_r;
        end
      endcase
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (in_fire) begin
      if (in_req_type == gbr_pkg::REQ_PIXEL) begin
        if (in_origin) begin
          out_col_use = '0;
          out_row_use = '0;
        end
        emit = (in_row_r >= FH_W'(2)) || ((in_row_r == FH_W'(1)) && (in_col_r != '0));
        s1_v_nxt     = 1'b1;
        s1_shift_nxt = 1'b1;
        if (in_col_r == w_last_r) begin
          in_col_nxt = '0;
          in_row_nxt = (in_row_r == h_last_r) ? '0 : in_row_r + FH_W'(1);
        end else begin
          in_col_nxt = in_col_r + CW'(1);
        end
      end else if (in_origin && !out_origin) begin
        emit     = 1'b1;
        s1_v_nxt = 1'b1;
      end
      out_col_nxt = out_col_use;
      out_row_nxt = out_row_use;
      if (emit) begin
        if (out_col_use == w_last_r) begin
          out_col_nxt = '0;
          out_row_nxt = (out_row_use == h_last_r) ? '0 : out_row_use + FH_W'(1);
        end else begin
          out_col_nxt = out_col_use + CW'(1);
        end
      end
    end
    s1_emit_nxt = emit;
    s1_zero_nxt = (out_row_use == '0) || (out_col_use == '0) ||
                  (out_row_use == h_last_r) || (out_col_use == w_last_r);
    s1_last_nxt = (out_row_use == h_last_r) && (out_col_use == w_last_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r   <= CW'(RST_W - 1);
      h_last_r   <= FH_W'(gbr_pkg::FRAME_HEIGHT_RST - 1);
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      s1_v_r     <= 1'b0;
      s1_shift_r <= 1'b0;
    end else begin
      w_last_r   <= w_last_nxt;
      h_last_r   <= h_last_nxt;
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      s1_v_r     <= s1_v_nxt;
      s1_shift_r <= s1_shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_emit_r <= s1_emit_nxt;
    s1_zero_r <= s1_zero_nxt;
    s1_last_r <= s1_last_nxt;
    s1_col_r  <= in_col_r;
    s1_px_r   <= in_px;
  end

  // upper half holds the row two above the input, lower half the previous row
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= line_mem[in_col_r];
    end
    if (s1_v_r && s1_shift_r) begin
      line_mem[s1_col_r] <= {rd_data_r[PX_W-1:0], s1_px_r};
    end
  end

  assign push_valid     = s1_v_r;
  assign push_data.shift = s1_shift_r;
  assign push_data.emit  = s1_emit_r;
  assign push_data.zero  = s1_zero_r;
  assign push_data.last  = s1_last_r;
  assign push_data.top   = rd_data_r[2*PX_W-1:PX_W];
  assign push_data.mid   = rd_data_r[PX_W-1:0];
  assign push_data.px    = s1_px_r;

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (q_count < gbr_pkg::QCNT_W'(gbr_pkg::QUEUE_DEPTH)))
    else $error("command pushed into a full queue");

  a_first_px_resets_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !cfg_fire && (in_req_type == gbr_pkg::REQ_PIXEL) && in_origin)
    |=> (out_row_r == '0) && (out_col_r == '0))
    else $error("first pixel of frame did not restart output position");

  a_drain_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !cfg_fire && (in_req_type == gbr_pkg::REQ_DRAIN) && !in_origin)
    |=> !s1_v_r)
    else $error("drain mid-frame produced a command");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (in_col_r <= w_last_r) && (out_col_r <= w_last_r))
    else $error("column counter beyond frame width");

endmodule

// ===== sv/gbr_queue.sv =====
// Short command queue between front end and back end.
// Payload type and depth from gbr_pkg.
module gbr_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_valid,
  input  gbr_pkg::cmd_t              push_data,
  output logic                       pop_valid,
  input  logic                       pop_ready,
  output gbr_pkg::cmd_t              pop_data,
  output logic [gbr_pkg::QCNT_W-1:0] count
);

  localparam int unsigned DEPTH = gbr_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  gbr_pkg::cmd_t               slot_r [DEPTH];
  logic [PTR_W-1:0]            wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [gbr_pkg::QCNT_W-1:0]  count_r, count_nxt;
  logic                        push, pop;

  assign pop_valid = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign count     = count_r;
  assign push      = push_valid && (count_r != gbr_pkg::QCNT_W'(DEPTH));
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + gbr_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - gbr_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/gbr_back.sv =====
// Back end: 3x3 pixel window, per-channel 1-2-1 kernel and output register.
// Takes commands from gbr_queue; uses gbr_pkg.
module gbr_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     pop_valid,
  output logic                     pop_ready,
  input  gbr_pkg::cmd_t            pop_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [gbr_pkg::PX_W-1:0] out_px,
  output logic                     out_last
);

  localparam int unsigned CH_W  = gbr_pkg::CH_W;
  localparam int unsigned PX_W  = gbr_pkg::PX_W;
  localparam int unsigned SUM_W = CH_W + 4;

  logic [PX_W-1:0]  win_r [3][3];
  logic             tag_v_r, tag_v_nxt;
  logic             tag_zero_r, tag_last_r;
  logic             out_v_r, out_v_nxt;
  logic [PX_W-1:0]  out_px_r;
  logic             out_last_r;

  logic             out_adv, tag_move, pop;
  logic [PX_W-1:0]  blur_px;
  logic [SUM_W-1:0] sum;

  assign out_adv   = !out_v_r || out_ready;
  assign tag_move  = tag_v_r && out_adv;
  assign pop_ready = !tag_v_r || tag_move;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    blur_px = '0;
    sum     = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum = SUM_W'(win_r[0][0][ch*CH_W +: CH_W]) +
            (SUM_W'(win_r[0][1][ch*CH_W +: CH_W]) << 1) +
            SUM_W'(win_r[0][2][ch*CH_W +: CH_W]) +
            (SUM_W'(win_r[1][0][ch*CH_W +: CH_W]) << 1) +
            (SUM_W'(win_r[1][1][ch*CH_W +: CH_W]) << 2) +
            (SUM_W'(win_r[1][2][ch*CH_W +: CH_W]) << 1) +
            SUM_W'(win_r[2][0][ch*CH_W +: CH_W]) +
            (SUM_W'(win_r[2][1][ch*CH_W +: CH_W]) << 1) +
            SUM_W'(win_r[2][2][ch*CH_W +: CH_W]);
      blur_px[ch*CH_W +: CH_W] = sum[SUM_W-1:4];
    end
  end

  always_comb begin
    tag_v_nxt = tag_v_r;
    if (pop) begin
      tag_v_nxt = pop_data.emit;
    end else if (tag_move) begin
      tag_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (tag_move) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      tag_v_r <= tag_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tag_zero_r <= pop_data.zero;
      tag_last_r <= pop_data.last;
      if (pop_data.shift) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= pop_data.top;
        win_r[1][2] <= pop_data.mid;
        win_r[2][2] <= pop_data.px;
      end
    end
    if (tag_move) begin
      out_px_r   <= tag_zero_r ? '0 : blur_px;
      out_last_r <= tag_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_px    = out_px_r;
  assign out_last  = out_last_r;

  a_tag_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    tag_move |=> out_v_r)
    else $error("window result lost on its way to the output register");

  a_last_is_border: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_last_r) |-> (out_px_r == '0))
    else $error("final pixel of frame not zero");

  a_drain_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !pop_data.shift) |-> pop_data.emit)
    else $error("drain command without a result");

endmodule

// ===== sv/gaussian_blur_3x3_rgb.sv =====
// Streaming 3x3 Gaussian blur of a raster-order RGB frame, top level.
// Throughput: one beat per cycle on input and output when not stalled.
// Path: an accepted beat passes the front stage register, a queue slot and the window stage
// before the output register raises out_valid; results trail input by one row plus one pixel.
// Reset: frame 640 x 480, position counters zero, line buffers not cleared.
// Instantiates gbr_front, gbr_queue and gbr_back; uses gbr_pkg.
module gaussian_blur_3x3_rgb #(
  parameter int unsigned MAX_WIDTH = gbr_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [gbr_pkg::CH_W-1:0]       in_red,
  input  logic [gbr_pkg::CH_W-1:0]       in_green,
  input  logic [gbr_pkg::CH_W-1:0]       in_blue,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gbr_pkg::CH_W-1:0]       out_red,
  output logic [gbr_pkg::CH_W-1:0]       out_green,
  output logic [gbr_pkg::CH_W-1:0]       out_blue,
  output logic                           out_frame_last
);

  localparam int unsigned CH_W = gbr_pkg::CH_W;

  logic                       push_valid, pop_valid, pop_ready;
  gbr_pkg::cmd_t              push_data, pop_data;
  logic [gbr_pkg::QCNT_W-1:0] q_count;
  logic [gbr_pkg::PX_W-1:0]   in_px, out_px;

  assign in_px = {in_blue, in_green, in_red};

  gbr_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_px       (in_px),
    .q_count     (q_count),
    .push_valid  (push_valid),
    .push_data   (push_data)
  );

  gbr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .count      (q_count)
  );

  gbr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_px    (out_px),
    .out_last  (out_frame_last)
  );

  assign out_red   = out_px[CH_W-1:0];
  assign out_green = out_px[2*CH_W-1:CH_W];
  assign out_blue  = out_px[3*CH_W-1:2*CH_W];

endmodule
